FILE: sv/ebin_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebin_pkg
// Shared widths, status codes and register indexes of the equal population
// binner.
// ----------------------------------------------------------------------------
package ebin_pkg;

    // field widths
    localparam int SAMPLE_W    = 32;
    localparam int LABEL_W     = 4;
    localparam int STATUS_W    = 2;
    localparam int COST_W      = 32;
    localparam int NUM_BINS_W  = 5;

    // configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_BINS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SORTED_MODE = 2'd1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNSORTED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FEW_GROUPS = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_MANY   = 2'd3;

endpackage

FILE: sv/ebin_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebin_in_if
// Sample channel: one sample word with its end-of-set flag.
// ----------------------------------------------------------------------------
interface ebin_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ebin_pkg::SAMPLE_W-1:0]  sample;
    logic                                  last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

FILE: sv/ebin_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebin_out_if
// Label channel: one bin label word per sample, in arrival order.
// ----------------------------------------------------------------------------
interface ebin_out_if;
    logic                            valid;
    logic                            ready;
    logic [ebin_pkg::LABEL_W-1:0]    bin_label;
    logic [ebin_pkg::STATUS_W-1:0]   status;
    logic                            last_label;

    modport source (output valid, output bin_label, output status, output last_label,
                    input ready);
    modport sink   (input valid, input bin_label, input status, input last_label,
                    output ready);
endinterface

FILE: sv/ebin_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebin_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ebin_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

FILE: sv/ebin_cost_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebin_cost_unit
// Shared two-stage cost datapath: deviation of a bin count scaled by the
// bin number, then square plus predecessor cost.
// ----------------------------------------------------------------------------
module ebin_cost_unit #(
    parameter int CNTW = 7,
    parameter int BW   = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req,
    input  logic [CNTW-1:0]               cnt,
    input  logic [BW-1:0]                 nb,
    input  logic [CNTW-1:0]               n,
    input  logic [ebin_pkg::COST_W-1:0]   base,
    output logic                          done,
    output logic [ebin_pkg::COST_W-1:0]   cost
);
    localparam int DW = CNTW + BW + 1;

    logic                          s1_valid_reg;
    logic signed [DW-1:0]          dev_reg;
    logic [ebin_pkg::COST_W-1:0]   base_reg;
    logic                          s2_valid_reg;
    logic [ebin_pkg::COST_W-1:0]   cost_reg;

    logic [CNTW+BW-1:0]            prod;
    logic signed [DW-1:0]          dev_next;
    logic signed [2*DW-1:0]        sq;

    // stage one: count times bins minus set size
    assign prod     = (CNTW+BW)'(cnt) * (CNTW+BW)'(nb);
    assign dev_next = $signed({1'b0, prod}) - $signed(DW'(n));

    // stage two: square and accumulate
    assign sq = dev_reg * dev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= req;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dev_reg  <= dev_next;
        base_reg <= base;
        cost_reg <= base_reg + ebin_pkg::COST_W'($unsigned(sq));
    end

    assign done = s2_valid_reg;
    assign cost = cost_reg;
endmodule

FILE: sv/equal_population_binner_core.sv
`timescale 1ns / 1ps
// Samples are taken one per cycle while a set is collected; after the final
// sample, planning ranks every sample (unsorted mode) or checks the order,
// groups ties, runs the cost loop over every candidate cut, labels the
// samples, then emits the label words.
// Throughput: one set at a time through the shared cost unit and RAM ports.
// Reset: control and configuration registers cleared; working registers and RAM contents undefined, no clear pass.
// ----------------------------------------------------------------------------
// equal_population_binner_core
// Collects a sample set, orders and groups it, runs the bin cut search on a
// shared cost unit, and emits one bin label word per sample.
// ----------------------------------------------------------------------------
module equal_population_binner_core #(
    parameter int MAX_SAMPLES = 64,
    parameter int MAX_BINS    = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [ebin_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ebin_pkg::CFG_DATA_W-1:0]      cfg_data,
    ebin_in_if.sink                              samples,
    ebin_out_if.source                           labels
);
    localparam int IDXW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNTW   = $clog2(MAX_SAMPLES + 1);
    localparam int BW     = $clog2(MAX_BINS + 1);
    localparam int CDEPTH = (MAX_BINS + 1) * (2 ** CNTW);
    localparam int SW     = ebin_pkg::SAMPLE_W;
    localparam int LW     = ebin_pkg::LABEL_W;
    localparam int CW     = ebin_pkg::COST_W;

    // sequencer states
    localparam logic [4:0] S_COLLECT = 5'd0;
    localparam logic [4:0] S_CHK_RD  = 5'd1;
    localparam logic [4:0] S_CHK_CMP = 5'd2;
    localparam logic [4:0] S_RK_LD   = 5'd3;
    localparam logic [4:0] S_RK_LDW  = 5'd4;
    localparam logic [4:0] S_RK_RD   = 5'd5;
    localparam logic [4:0] S_RK_CMP  = 5'd6;
    localparam logic [4:0] S_RK_WR   = 5'd7;
    localparam logic [4:0] S_GRP     = 5'd8;
    localparam logic [4:0] S_G_ORD   = 5'd9;
    localparam logic [4:0] S_G_SMP   = 5'd10;
    localparam logic [4:0] S_G_CMP   = 5'd11;
    localparam logic [4:0] S_G_END   = 5'd12;
    localparam logic [4:0] S_G_TST   = 5'd13;
    localparam logic [4:0] S_DP_INIT = 5'd14;
    localparam logic [4:0] S_DP_G    = 5'd15;
    localparam logic [4:0] S_DP_GW   = 5'd16;
    localparam logic [4:0] S_DP_RD   = 5'd17;
    localparam logic [4:0] S_DP_MUL  = 5'd18;
    localparam logic [4:0] S_DP_W1   = 5'd19;
    localparam logic [4:0] S_DP_CMP  = 5'd20;
    localparam logic [4:0] S_DP_WR   = 5'd21;
    localparam logic [4:0] S_BT_RD   = 5'd22;
    localparam logic [4:0] S_BT_W    = 5'd23;
    localparam logic [4:0] S_BT_RS   = 5'd24;
    localparam logic [4:0] S_BT_RSW  = 5'd25;
    localparam logic [4:0] S_LB_RD   = 5'd26;
    localparam logic [4:0] S_LB_WR   = 5'd27;
    localparam logic [4:0] S_EM_RD   = 5'd28;
    localparam logic [4:0] S_EM_OUT  = 5'd29;

    // control registers
    logic [4:0]                        state_reg, state_next;
    logic [CNTW-1:0]                   count_reg, count_next;
    logic [ebin_pkg::STATUS_W-1:0]     err_reg, err_next;
    logic [ebin_pkg::NUM_BINS_W-1:0]   num_bins_reg;
    logic                              sorted_reg;
    logic                              ovalid_reg, ovalid_next;

    // working registers
    logic [CNTW-1:0]                   n_reg, n_next;
    logic [CNTW-1:0]                   i_reg, i_next;
    logic [CNTW-1:0]                   j_reg, j_next;
    logic [CNTW-1:0]                   p_reg, p_next;
    logic [CNTW-1:0]                   rank_reg, rank_next;
    logic [SW-1:0]                     key_reg, key_next;
    logic [SW-1:0]                     pval_reg, pval_next;
    logic [CNTW-1:0]                   grp_reg, grp_next;
    logic [CNTW-1:0]                   groups_reg, groups_next;
    logic [BW-1:0]                     b_reg, b_next;
    logic [CNTW-1:0]                   g_reg, g_next;
    logic [CNTW-1:0]                   prev_reg, prev_next;
    logic [CNTW-1:0]                   gsg_reg, gsg_next;
    logic [CNTW-1:0]                   stop_reg, stop_next;
    logic [CW-1:0]                     best_reg, best_next;
    logic [CNTW-1:0]                   bestp_reg, bestp_next;
    logic                              found_reg, found_next;
    logic [LW-1:0]                     olabel_reg, olabel_next;
    logic [ebin_pkg::STATUS_W-1:0]     ostatus_reg, ostatus_next;
    logic                              olast_reg, olast_next;

    // ram ports
    logic                  smp_we;
    logic [IDXW-1:0]       smp_wa, smp_ra;
    logic [SW-1:0]         smp_rd;
    logic                  ord_we;
    logic [IDXW-1:0]       ord_wa, ord_wd, ord_ra, ord_rd;
    logic                  gs_we;
    logic [CNTW-1:0]       gs_wa, gs_wd, gs_ra, gs_rd;
    logic                  cst_we;
    logic [BW+CNTW-1:0]    cst_wa, cst_ra;
    logic [CW-1:0]         cst_wd, cst_rd;
    logic                  prd_we;
    logic [BW+CNTW-1:0]    prd_ra;
    logic [CNTW-1:0]       prd_rd;
    logic                  lbl_we;
    logic [IDXW-1:0]       lbl_wa, lbl_ra;
    logic [LW-1:0]         lbl_wd, lbl_rd;

    // cost unit
    logic                  cu_req, cu_done;
    logic [CNTW-1:0]       cu_cnt;
    logic [CW-1:0]         cu_cost;

    logic [BW-1:0]         nb_eff;
    logic                  accept;
    logic                  rank_lt;
    logic [CNTW-1:0]       last_prev;

    // effective bin count, clamped to one and to the maximum
    always_comb
    begin
        if (num_bins_reg == '0)
            nb_eff = BW'(1);
        else if (32'(num_bins_reg) > 32'(MAX_BINS))
            nb_eff = BW'(MAX_BINS);
        else
            nb_eff = BW'(num_bins_reg);
    end

    assign accept  = samples.valid && samples.ready;
    assign samples.ready = (state_reg == S_COLLECT);
    assign rank_lt = ($signed(smp_rd) < $signed(key_reg)) ||
                     ((smp_rd == key_reg) && (j_reg < i_reg));
    assign last_prev = (b_reg == BW'(1)) ? '0 : (g_reg - 1'b1);
    assign cu_req = (state_reg == S_DP_MUL);
    assign cu_cnt = gsg_reg - gs_rd;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_bins_reg <= ebin_pkg::NUM_BINS_W'(1);
            sorted_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == ebin_pkg::REG_NUM_BINS)
                num_bins_reg <= cfg_data[ebin_pkg::NUM_BINS_W-1:0];
            else if (cfg_index == ebin_pkg::REG_SORTED_MODE)
                sorted_reg <= cfg_data[0];
        end
    end

    // sequencer next state and ram control
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        err_next     = err_reg;
        ovalid_next  = ovalid_reg && !labels.ready;
        n_next       = n_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        p_next       = p_reg;
        rank_next    = rank_reg;
        key_next     = key_reg;
        pval_next    = pval_reg;
        grp_next     = grp_reg;
        groups_next  = groups_reg;
        b_next       = b_reg;
        g_next       = g_reg;
        prev_next    = prev_reg;
        gsg_next     = gsg_reg;
        stop_next    = stop_reg;
        best_next    = best_reg;
        bestp_next   = bestp_reg;
        found_next   = found_reg;
        olabel_next  = olabel_reg;
        ostatus_next = ostatus_reg;
        olast_next   = olast_reg;

        smp_we = 1'b0;
        smp_wa = count_reg[IDXW-1:0];
        smp_ra = i_reg[IDXW-1:0];
        ord_we = 1'b0;
        ord_wa = i_reg[IDXW-1:0];
        ord_wd = i_reg[IDXW-1:0];
        ord_ra = p_reg[IDXW-1:0];
        gs_we  = 1'b0;
        gs_wa  = grp_reg + 1'b1;
        gs_wd  = p_reg;
        gs_ra  = g_reg;
        cst_we = 1'b0;
        cst_wa = {b_reg, g_reg};
        cst_wd = best_reg;
        cst_ra = {b_reg - 1'b1, prev_reg};
        prd_we = 1'b0;
        prd_ra = {b_reg, g_reg};
        lbl_we = 1'b0;
        lbl_wa = ord_rd;
        lbl_wd = LW'(b_reg - 1'b1);
        lbl_ra = i_reg[IDXW-1:0];

        case (state_reg)
            // collect samples until the flagged one
            S_COLLECT:
            begin
                if (accept)
                begin
                    if (32'(count_reg) < 32'(MAX_SAMPLES))
                    begin
                        smp_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        err_next = ebin_pkg::ST_TOO_MANY;
                    end
                    if (samples.last_sample)
                    begin
                        n_next = count_next;
                        i_next = '0;
                        if (err_next != ebin_pkg::ST_OK)
                            state_next = S_EM_RD;
                        else if (sorted_reg)
                            state_next = S_CHK_RD;
                        else
                            state_next = S_RK_LD;
                    end
                end
            end
            // sorted mode: check order, identity permutation
            S_CHK_RD:
            begin
                state_next = S_CHK_CMP;
            end
            S_CHK_CMP:
            begin
                ord_we = 1'b1;
                if ((i_reg != '0) && ($signed(smp_rd) < $signed(pval_reg)))
                begin
                    err_next   = ebin_pkg::ST_UNSORTED;
                    i_next     = '0;
                    state_next = S_EM_RD;
                end
                else
                begin
                    pval_next = smp_rd;
                    i_next    = i_reg + 1'b1;
                    if ((i_reg + 1'b1) == n_reg)
                        state_next = S_GRP;
                    else
                        state_next = S_CHK_RD;
                end
            end
            // unsorted mode: stable rank of each sample
            S_RK_LD:
            begin
                state_next = S_RK_LDW;
            end
            S_RK_LDW:
            begin
                key_next   = smp_rd;
                j_next     = '0;
                rank_next  = '0;
                state_next = S_RK_RD;
            end
            S_RK_RD:
            begin
                smp_ra     = j_reg[IDXW-1:0];
                state_next = S_RK_CMP;
            end
            S_RK_CMP:
            begin
                if (rank_lt)
                    rank_next = rank_reg + 1'b1;
                j_next = j_reg + 1'b1;
                if ((j_reg + 1'b1) == n_reg)
                    state_next = S_RK_WR;
                else
                    state_next = S_RK_RD;
            end
            S_RK_WR:
            begin
                ord_we = 1'b1;
                ord_wa = rank_reg[IDXW-1:0];
                i_next = i_reg + 1'b1;
                if ((i_reg + 1'b1) == n_reg)
                    state_next = S_GRP;
                else
                    state_next = S_RK_LD;
            end
            // tie group boundaries over the ordered samples
            S_GRP:
            begin
                gs_we      = 1'b1;
                gs_wa      = '0;
                gs_wd      = '0;
                p_next     = '0;
                grp_next   = '0;
                state_next = S_G_ORD;
            end
            S_G_ORD:
            begin
                state_next = S_G_SMP;
            end
            S_G_SMP:
            begin
                smp_ra     = ord_rd;
                state_next = S_G_CMP;
            end
            S_G_CMP:
            begin
                if ((p_reg != '0) && (smp_rd != pval_reg))
                begin
                    gs_we    = 1'b1;
                    grp_next = grp_reg + 1'b1;
                end
                pval_next = smp_rd;
                p_next    = p_reg + 1'b1;
                if ((p_reg + 1'b1) == n_reg)
                    state_next = S_G_END;
                else
                    state_next = S_G_ORD;
            end
            S_G_END:
            begin
                gs_we       = 1'b1;
                gs_wd       = n_reg;
                groups_next = grp_reg + 1'b1;
                state_next  = S_G_TST;
            end
            S_G_TST:
            begin
                if (32'(groups_reg) < 32'(nb_eff))
                begin
                    err_next   = ebin_pkg::ST_FEW_GROUPS;
                    i_next     = '0;
                    state_next = S_EM_RD;
                end
                else
                begin
                    state_next = S_DP_INIT;
                end
            end
            // cut search: row zero seed
            S_DP_INIT:
            begin
                cst_we     = 1'b1;
                cst_wa     = '0;
                cst_wd     = '0;
                b_next     = BW'(1);
                g_next     = CNTW'(1);
                state_next = S_DP_G;
            end
            S_DP_G:
            begin
                prev_next  = CNTW'(b_reg - 1'b1);
                found_next = 1'b0;
                state_next = S_DP_GW;
            end
            S_DP_GW:
            begin
                gsg_next   = gs_rd;
                state_next = S_DP_RD;
            end
            S_DP_RD:
            begin
                gs_ra      = prev_reg;
                state_next = S_DP_MUL;
            end
            S_DP_MUL:
            begin
                state_next = S_DP_W1;
            end
            S_DP_W1:
            begin
                state_next = S_DP_CMP;
            end
            S_DP_CMP:
            begin
                if (!found_reg || (cu_cost < best_reg))
                begin
                    best_next  = cu_cost;
                    bestp_next = prev_reg;
                    found_next = 1'b1;
                end
                if (prev_reg == last_prev)
                begin
                    state_next = S_DP_WR;
                end
                else
                begin
                    prev_next  = prev_reg + 1'b1;
                    state_next = S_DP_RD;
                end
            end
            S_DP_WR:
            begin
                cst_we = 1'b1;
                prd_we = 1'b1;
                if ((32'(g_reg) + 32'd1) > (32'(groups_reg) - 32'(nb_eff) + 32'(b_reg)))
                begin
                    if (b_reg == nb_eff)
                    begin
                        g_next     = groups_reg;
                        state_next = S_BT_RD;
                    end
                    else
                    begin
                        b_next     = b_reg + 1'b1;
                        g_next     = CNTW'(b_reg + 1'b1);
                        state_next = S_DP_G;
                    end
                end
                else
                begin
                    g_next     = g_reg + 1'b1;
                    state_next = S_DP_G;
                end
            end
            // backtrack one bin and label its samples
            S_BT_RD:
            begin
                state_next = S_BT_W;
            end
            S_BT_W:
            begin
                stop_next  = gs_rd;
                prev_next  = prd_rd;
                state_next = S_BT_RS;
            end
            S_BT_RS:
            begin
                gs_ra      = prev_reg;
                state_next = S_BT_RSW;
            end
            S_BT_RSW:
            begin
                p_next     = gs_rd;
                state_next = S_LB_RD;
            end
            S_LB_RD:
            begin
                if (p_reg == stop_reg)
                begin
                    g_next = prev_reg;
                    b_next = b_reg - 1'b1;
                    if (b_reg == BW'(1))
                    begin
                        i_next     = '0;
                        state_next = S_EM_RD;
                    end
                    else
                    begin
                        state_next = S_BT_RD;
                    end
                end
                else
                begin
                    state_next = S_LB_WR;
                end
            end
            S_LB_WR:
            begin
                lbl_we     = 1'b1;
                p_next     = p_reg + 1'b1;
                state_next = S_LB_RD;
            end
            // emit label words in arrival order
            S_EM_RD:
            begin
                state_next = S_EM_OUT;
            end
            S_EM_OUT:
            begin
                if (!ovalid_reg || labels.ready)
                begin
                    ovalid_next  = 1'b1;
                    olabel_next  = (err_reg == ebin_pkg::ST_OK) ? lbl_rd : '0;
                    ostatus_next = err_reg;
                    olast_next   = ((i_reg + 1'b1) == n_reg);
                    if ((i_reg + 1'b1) == n_reg)
                    begin
                        count_next = '0;
                        err_next   = ebin_pkg::ST_OK;
                        state_next = S_COLLECT;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_EM_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_COLLECT;
            count_reg  <= '0;
            err_reg    <= ebin_pkg::ST_OK;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            err_reg    <= err_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        p_reg       <= p_next;
        rank_reg    <= rank_next;
        key_reg     <= key_next;
        pval_reg    <= pval_next;
        grp_reg     <= grp_next;
        groups_reg  <= groups_next;
        b_reg       <= b_next;
        g_reg       <= g_next;
        prev_reg    <= prev_next;
        gsg_reg     <= gsg_next;
        stop_reg    <= stop_next;
        best_reg    <= best_next;
        bestp_reg   <= bestp_next;
        found_reg   <= found_next;
        olabel_reg  <= olabel_next;
        ostatus_reg <= ostatus_next;
        olast_reg   <= olast_next;
    end

    // output word
    assign labels.valid      = ovalid_reg;
    assign labels.bin_label  = olabel_reg;
    assign labels.status     = ostatus_reg;
    assign labels.last_label = olast_reg;

    // storage
    ebin_ram #(.WIDTH(SW), .DEPTH(MAX_SAMPLES)) u_sample_ram (
        .clk(clk), .we(smp_we), .wr_addr(smp_wa), .wr_data(samples.sample),
        .rd_addr(smp_ra), .rd_data(smp_rd)
    );

    ebin_ram #(.WIDTH(IDXW), .DEPTH(MAX_SAMPLES)) u_order_ram (
        .clk(clk), .we(ord_we), .wr_addr(ord_wa), .wr_data(ord_wd),
        .rd_addr(ord_ra), .rd_data(ord_rd)
    );

    ebin_ram #(.WIDTH(CNTW), .DEPTH(MAX_SAMPLES + 1)) u_group_ram (
        .clk(clk), .we(gs_we), .wr_addr(gs_wa), .wr_data(gs_wd),
        .rd_addr(gs_ra), .rd_data(gs_rd)
    );

    ebin_ram #(.WIDTH(CW), .DEPTH(CDEPTH)) u_cost_ram (
        .clk(clk), .we(cst_we), .wr_addr(cst_wa), .wr_data(cst_wd),
        .rd_addr(cst_ra), .rd_data(cst_rd)
    );

    ebin_ram #(.WIDTH(CNTW), .DEPTH(CDEPTH)) u_pred_ram (
        .clk(clk), .we(prd_we), .wr_addr(cst_wa), .wr_data(bestp_reg),
        .rd_addr(prd_ra), .rd_data(prd_rd)
    );

    ebin_ram #(.WIDTH(LW), .DEPTH(MAX_SAMPLES)) u_label_ram (
        .clk(clk), .we(lbl_we), .wr_addr(lbl_wa), .wr_data(lbl_wd),
        .rd_addr(lbl_ra), .rd_data(lbl_rd)
    );

    // shared cost datapath
    ebin_cost_unit #(.CNTW(CNTW), .BW(BW)) u_cost (
        .clk(clk), .rst_n(rst_n), .req(cu_req), .cnt(cu_cnt), .nb(nb_eff),
        .n(n_reg), .base(cst_rd), .done(cu_done), .cost(cu_cost)
    );

    // checks
    a_cost_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DP_CMP) |-> cu_done)
        else $error("cost result missing at compare");

    a_dp_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DP_WR) |-> found_reg)
        else $error("cut search row entry without predecessor");

    a_dp_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DP_WR) |-> (err_reg == ebin_pkg::ST_OK))
        else $error("cut search running with error pending");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg == S_EM_OUT))
        else $error("label word raised outside emit");
endmodule

FILE: test/ebin_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebin_checker
// Watches the sample and label channels and the register port, keeps its own
// copy of the registers and the sample set, works out the bin label words of
// each completed set and compares every label word with the oldest pending one.
// ----------------------------------------------------------------------------
module ebin_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ebin_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ebin_pkg::CFG_DATA_W-1:0] cfg_data,
    ebin_in_if                             samples,
    ebin_out_if                            labels,
    output int                             fail_count,
    output int                             pending
);
    localparam int SET_MAX  = 64;
    localparam int BINS_MAX = 16;

    typedef struct packed {
        logic [ebin_pkg::LABEL_W-1:0]  bin_label;
        logic [ebin_pkg::STATUS_W-1:0] status;
        logic                          last_label;
    } label_word_t;

    label_word_t                          label_q[$];
    logic [ebin_pkg::NUM_BINS_W-1:0]      bins_reg;
    logic                                 sorted_reg;
    logic signed [ebin_pkg::SAMPLE_W-1:0] set_vals[SET_MAX];
    int                                   set_len;
    logic                                 overflow;

    // order, group and cut search of one completed set; queues its label words
    task automatic plan_set();
        int nb;
        int n;
        int order[SET_MAX];
        int gstart[SET_MAX+1];
        int groups;
        longint cost[BINS_MAX+1][SET_MAX+1];
        int pred[BINS_MAX+1][SET_MAX+1];
        bit cv[BINS_MAX+1][SET_MAX+1];
        int cuts[BINS_MAX+1];
        int lab[SET_MAX];
        logic [ebin_pkg::STATUS_W-1:0] st;
        int cur, p, gmax, cnt, dev, best_prev;
        longint best, c;
        bit found;
        label_word_t w;

        n  = set_len;
        nb = (bins_reg < 1) ? 1 : ((bins_reg > BINS_MAX) ? BINS_MAX : int'(bins_reg));
        st = overflow ? ebin_pkg::ST_TOO_MANY : ebin_pkg::ST_OK;
        for (int i = 0; i < SET_MAX; i++)
        begin
            order[i] = i;
            lab[i]   = 0;
        end
        // sorted mode check or stable ordering by value
        if (st == ebin_pkg::ST_OK && sorted_reg)
        begin
            for (int i = 1; i < n; i++)
                if (set_vals[i] < set_vals[i-1])
                    st = ebin_pkg::ST_UNSORTED;
        end
        else if (st == ebin_pkg::ST_OK)
        begin
            for (int i = 1; i < n; i++)
            begin
                cur = order[i];
                p   = i;
                while (p > 0 && set_vals[order[p-1]] > set_vals[cur])
                begin
                    order[p] = order[p-1];
                    p--;
                end
                order[p] = cur;
            end
        end
        // tie groups
        if (st == ebin_pkg::ST_OK)
        begin
            groups    = 0;
            gstart[0] = 0;
            for (int i = 1; i < n; i++)
                if (set_vals[order[i]] != set_vals[order[i-1]])
                begin
                    groups++;
                    gstart[groups] = i;
                end
            groups++;
            gstart[groups] = n;
            if (groups < nb)
                st = ebin_pkg::ST_FEW_GROUPS;
        end
        // cut search, earliest predecessor wins on a tie
        if (st == ebin_pkg::ST_OK)
        begin
            for (int b = 0; b <= BINS_MAX; b++)
                for (int g = 0; g <= SET_MAX; g++)
                    cv[b][g] = 1'b0;
            cost[0][0] = 0;
            pred[0][0] = 0;
            cv[0][0]   = 1'b1;
            for (int b = 1; b <= nb; b++)
            begin
                gmax = groups - (nb - b);
                for (int g = b; g <= gmax; g++)
                begin
                    found     = 1'b0;
                    best      = 0;
                    best_prev = 0;
                    for (int pv = b - 1; pv < g; pv++)
                    begin
                        if (cv[b-1][pv])
                        begin
                            cnt = gstart[g] - gstart[pv];
                            dev = cnt * nb - n;
                            c   = cost[b-1][pv] + longint'(dev * dev);
                            if (!found || c < best)
                            begin
                                best      = c;
                                best_prev = pv;
                                found     = 1'b1;
                            end
                        end
                    end
                    cost[b][g] = best;
                    pred[b][g] = best_prev;
                    cv[b][g]   = found;
                end
            end
            if (!cv[nb][groups])
                st = ebin_pkg::ST_FEW_GROUPS;
        end
        // backtrack and label in arrival order
        if (st == ebin_pkg::ST_OK)
        begin
            cuts[nb] = groups;
            cur = groups;
            for (int b = nb; b > 0; b--)
            begin
                cuts[b-1] = pred[b][cur];
                cur = cuts[b-1];
            end
            for (int b = 0; b < nb; b++)
                for (int i = gstart[cuts[b]]; i < gstart[cuts[b+1]]; i++)
                    lab[order[i]] = b;
        end
        for (int i = 0; i < n; i++)
        begin
            w.bin_label  = (st == ebin_pkg::ST_OK) ? ebin_pkg::LABEL_W'(lab[i]) : '0;
            w.status     = st;
            w.last_label = (i + 1 == n);
            label_q.insert(label_q.size(), w);
        end
    endtask

    // register shadow, set capture and label word compare
    always @(posedge clk or negedge rst_n)
    begin
        label_word_t exp_w;
        if (!rst_n)
        begin
            bins_reg   <= 1;
            sorted_reg <= 1'b0;
            set_len    = 0;
            overflow   = 1'b0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_we && cfg_index == ebin_pkg::REG_NUM_BINS)
                bins_reg <= cfg_data[ebin_pkg::NUM_BINS_W-1:0];
            else if (cfg_we && cfg_index == ebin_pkg::REG_SORTED_MODE)
                sorted_reg <= cfg_data[0];
            if (samples.valid && samples.ready)
            begin
                if (set_len < SET_MAX)
                begin
                    set_vals[set_len] = samples.sample;
                    set_len++;
                end
                else
                    overflow = 1'b1;
                if (samples.last_sample)
                begin
                    plan_set();
                    set_len  = 0;
                    overflow = 1'b0;
                end
            end
            if (labels.valid && labels.ready)
            begin
                if (label_q.size() == 0)
                begin
                    $error("label word with none pending");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_w = label_q.pop_front();
                    if (labels.bin_label !== exp_w.bin_label)
                        $error("bin_label expected %0d actual %0d",
                               exp_w.bin_label, labels.bin_label);
                    if (labels.status !== exp_w.status)
                        $error("status expected %0d actual %0d",
                               exp_w.status, labels.status);
                    if (labels.last_label !== exp_w.last_label)
                        $error("last_label expected %0d actual %0d",
                               exp_w.last_label, labels.last_label);
                    if (labels.bin_label !== exp_w.bin_label
                        || labels.status !== exp_w.status
                        || labels.last_label !== exp_w.last_label)
                        fail_count <= fail_count + 1;
                end
            end
            pending <= label_q.size();
        end
    end
endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives sample sets into the equal population binner under several bin
// counts and both ordering modes, with random gaps on both channels; the
// checker beside the block predicts and compares every label word.
// ----------------------------------------------------------------------------
module tb_top;
    logic                              clk;
    logic                              rst_n;
    logic                              cfg_we;
    logic [ebin_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [ebin_pkg::CFG_DATA_W-1:0]   cfg_data;
    int                                fail_count;
    int                                pending;
    int                                words_sent;
    int                                big_left;
    bit                                tx_quiet;
    bit                                sorted_now;
    logic signed [ebin_pkg::SAMPLE_W-1:0] set_q[$];

    ebin_in_if  samples_if();
    ebin_out_if labels_if();

    equal_population_binner_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples_if),
        .labels    (labels_if)
    );

    ebin_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .samples    (samples_if),
        .labels     (labels_if),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // run limit
    initial
    begin
        #100ms;
        $display("FAILED: results differ");
        $finish;
    end

    // write one register once the block is idle
    task automatic write_reg(input logic [ebin_pkg::CFG_IDX_W-1:0] idx, input int val);
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= ebin_pkg::CFG_DATA_W'(val);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_mode(input int nb, input bit sm);
        write_reg(ebin_pkg::REG_NUM_BINS, nb);
        write_reg(ebin_pkg::REG_SORTED_MODE, sm);
        sorted_now = sm;
    endtask

    // send the queued set, last word flagged
    task automatic send_set();
        int gap;
        for (int i = 0; i < set_q.size(); i++)
        begin
            gap = tx_quiet ? 0 : $urandom_range(0, 17);
            if (gap > 0)
            begin
                samples_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            samples_if.valid       <= 1'b1;
            samples_if.sample      <= set_q[i];
            samples_if.last_sample <= (i == set_q.size() - 1);
            do
                @(posedge clk);
            while (!samples_if.ready);
            words_sent++;
        end
        samples_if.valid <= 1'b0;
    endtask

    // random set: full range, narrow range with ties, or few distinct values
    task automatic make_set(input int n, input bit make_sorted);
        int style;
        style = $urandom_range(0, 2);
        set_q.delete();
        for (int i = 0; i < n; i++)
            case (style)
                0: set_q.insert(set_q.size(), $urandom);
                1: set_q.insert(set_q.size(), $signed($urandom_range(0, 15)) - 8);
                default: set_q.insert(set_q.size(), $urandom_range(0, 2) * 32'h4000_0000);
            endcase
        if (make_sorted)
            set_q.sort();
    endtask

    // label receiver with random stalls and quiet stretches
    initial
    begin
        int gap;
        bit quiet;
        labels_if.ready = 1'b0;
        quiet = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 19) == 0)
                quiet = ($urandom_range(0, 2) == 0);
            gap = quiet ? 0 : $urandom_range(0, 17);
            if (gap > 0)
            begin
                labels_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            labels_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!labels_if.valid);
        end
    end

    // stimulus and verdict
    initial
    begin
        int n;
        samples_if.valid       = 1'b0;
        samples_if.sample      = '0;
        samples_if.last_sample = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        words_sent = 0;
        big_left   = 2;
        tx_quiet   = 1'b0;
        sorted_now = 1'b0;
        rst_n      = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // single sample at reset settings
        set_q = '{32'sh7fff_ffff};
        send_set();
        // extremes and ties, one bin
        set_q = '{32'sh8000_0000, 32'sh7fff_ffff, 0, 32'sh8000_0000};
        send_set();
        // two bins, sorting and tie groups kept whole
        set_mode(2, 1'b0);
        set_q = '{5, -3, 5, 5, -3, 9};
        send_set();
        // too few distinct values
        set_q = '{4, 4, 4};
        send_set();
        // sorted mode, in order and out of order
        set_mode(3, 1'b1);
        set_q = '{-7, -7, 0, 2, 2, 9};
        send_set();
        set_q = '{1, 3, 2};
        send_set();
        // zero bins acts as one, above the range acts as the maximum
        set_mode(0, 1'b0);
        write_reg(2'd2, 31);
        write_reg(2'd3, 31);
        set_q = '{3, 1, 2};
        send_set();
        set_mode(31, 1'b0);
        set_q = '{1, 2};
        send_set();

        // too many samples
        set_mode(4, 1'b0);
        make_set(66, 1'b0);
        send_set();

        // random sets under changing settings
        while (words_sent < 430)
        begin
            case ($urandom_range(0, 5))
                0: set_mode($urandom_range(0, 31), $urandom_range(0, 1));
                1: set_mode($urandom_range(1, 4), $urandom_range(0, 1));
                default: ;
            endcase
            tx_quiet = ($urandom_range(0, 3) == 0);
            n = $urandom_range(1, 14);
            if (big_left > 0 && $urandom_range(0, 39) == 0)
            begin
                n = (big_left == 2) ? 64 : $urandom_range(65, 70);
                big_left--;
            end
            make_set(n, sorted_now && ($urandom_range(0, 4) != 0));
            send_set();
        end

        // drain
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

FILE: equal_population_binner_core.f
sv/ebin_pkg.sv
sv/ebin_in_if.sv
sv/ebin_out_if.sv
sv/ebin_ram.sv
sv/ebin_cost_unit.sv
sv/equal_population_binner_core.sv
test/ebin_checker.sv
test/tb_top.sv
